// ===== sv/wpsv_pkg.sv =====
package wpsv_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 33;
  localparam int unsigned LenW     = 32;
  localparam int unsigned CountW   = 31;
  localparam int unsigned DurW     = 27;
  localparam int unsigned PeakW    = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned OutDataW = 96;

  localparam logic [CountW-1:0] MinSamplesRst  = 31'd2400;
  localparam logic [CountW-1:0] MaxSamplesRst  = 31'd480000;
  localparam logic [PeakW-1:0]  SilencePeakRst = 16'd64;

  localparam logic [CfgIdxW-1:0] CFG_MIN_SAMPLES  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SAMPLES  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SILENCE_PEAK = 2'd2;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CHDR   = 3'd1;
  localparam logic [2:0] PH_FMT    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_OTHER  = 3'd4;
  localparam logic [2:0] PH_PAD    = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID   = 3'd1;
  localparam logic [StatusW-1:0] ST_TRUNC     = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_FMT   = 3'd3;
  localparam logic [StatusW-1:0] ST_DUP_DATA  = 3'd4;
  localparam logic [StatusW-1:0] ST_BAD_STRUC = 3'd5;
  localparam logic [StatusW-1:0] ST_BAD_DUR   = 3'd6;

  localparam logic [LenW-1:0] TagFmt  = 32'h2074_6D66;
  localparam logic [LenW-1:0] TagData = 32'h6174_6164;

  localparam logic [PosW-1:0] MinFileLen = 33'd44;

  typedef struct packed {
    logic                quiet_flag;
    logic [PeakW-1:0]    peak_level;
    logic [DurW-1:0]     play_ms;
    logic [CountW-1:0]   sample_count;
    logic [StatusW-1:0]  status;
    logic [SampleW-1:0]  sample_q15;
  } result_t;

  typedef struct packed {
    logic    kind;
    result_t res;
  } entry_t;

  function automatic logic [ByteW-1:0] hdr_expect(input logic [3:0] idx);
    logic [ByteW-1:0] v;
    case (idx)
      4'd0:    v = 8'h52;
      4'd1:    v = 8'h49;
      4'd2:    v = 8'h46;
      4'd3:    v = 8'h46;
      4'd8:    v = 8'h57;
      4'd9:    v = 8'h41;
      4'd10:   v = 8'h56;
      4'd11:   v = 8'h45;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [ByteW-1:0] fmt_expect(input logic [3:0] idx);
    logic [ByteW-1:0] v;
    case (idx)
      4'd0:    v = 8'h01;
      4'd2:    v = 8'h01;
      4'd4:    v = 8'h80;
      4'd5:    v = 8'h3E;
      4'd14:   v = 8'h10;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic fmt_care(input logic [3:0] idx);
    return (idx < 4'd8) || (idx == 4'd14) || (idx == 4'd15);
  endfunction

endpackage

// ===== sv/wave_pcm16_stream_validator_top.sv =====
// Channel   | Dir | Payload
// s_axis    | in  | tdata: byte_value[7:0]; tlast: end_of_file
// m_axis    | out | tdata: sample, status, count, duration, peak, quiet_flag; tuser: kind
// cfg       | in  | cfg_we_i, cfg_addr_i, cfg_wdata_i; plain register writes
//
// One byte is parsed per cycle while s_axis_tready is high; the parser is a single registered pass.
// A byte can yield two words (last sample and summary); a 4-entry output
// queue takes them and s_axis_tready drops only when fewer than two slots are free.
// Reset (rst_ni low) clears parser state and the queue, registers go to defaults.
// After each summary the parser returns to its reset state.
module wave_pcm16_stream_validator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [wpsv_pkg::ByteW-1:0]         s_axis_tdata,  // byte_value
  input  logic                               s_axis_tlast,  // end_of_file
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sample_q15[15:0] status[18:16] sample_count[49:19] play_ms[76:50]
  // peak_level[92:77] quiet_flag[93] zero[95:94]
  output logic [wpsv_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                               m_axis_tuser,  // kind
  input  logic                               cfg_we_i,
  input  logic [wpsv_pkg::CfgIdxW-1:0]       cfg_addr_i,
  input  logic [wpsv_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic [wpsv_pkg::CountW-1:0] min_q, max_q;
  logic [wpsv_pkg::PeakW-1:0]  sil_q;

  logic [wpsv_pkg::PosW-1:0]    pos_q, pos_d;
  logic [wpsv_pkg::LenW-1:0]    riff_q, riff_d;
  logic [2:0]                   ph_q, ph_d;
  logic [wpsv_pkg::LenW-1:0]    tag_q, tag_d;
  logic [wpsv_pkg::LenW-1:0]    rem_q, rem_d;
  logic [3:0]                   fs_q, fs_d;
  logic                         fmt_seen_q, fmt_seen_d;
  logic                         data_seen_q, data_seen_d;
  logic [wpsv_pkg::LenW-1:0]    dbytes_q, dbytes_d;
  logic [8:0]                   hold_q, hold_d;
  logic [wpsv_pkg::PeakW-1:0]   peak_q, peak_d;
  logic [wpsv_pkg::StatusW-1:0] err_q, err_d;

  logic                         accept;
  logic                         emit_sample;
  logic [wpsv_pkg::SampleW-1:0] raw;
  logic [16:0]                  mag;
  logic [2:0]                   k;
  logic [3:0]                   off;
  logic [wpsv_pkg::LenW-1:0]    rem_dec;
  logic [wpsv_pkg::PosW:0]      body_end;
  logic [wpsv_pkg::PosW-1:0]    riff_total;
  logic [wpsv_pkg::CountW-1:0]  count;
  logic [wpsv_pkg::StatusW-1:0] status;
  logic [wpsv_pkg::ByteW-1:0]   b;

  wpsv_pkg::entry_t sample_e, summ_e, e0;

  wpsv_pkg::entry_t q_mem [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] n_push;
  logic       pop;

  assign b      = s_axis_tdata;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= wpsv_pkg::MinSamplesRst;
      max_q <= wpsv_pkg::MaxSamplesRst;
      sil_q <= wpsv_pkg::SilencePeakRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        wpsv_pkg::CFG_MIN_SAMPLES:  min_q <= cfg_wdata_i;
        wpsv_pkg::CFG_MAX_SAMPLES:  max_q <= cfg_wdata_i;
        wpsv_pkg::CFG_SILENCE_PEAK: sil_q <= cfg_wdata_i[wpsv_pkg::PeakW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d       = (pos_q == {wpsv_pkg::PosW{1'b1}}) ? pos_q :
                  pos_q + {{(wpsv_pkg::PosW-1){1'b0}}, 1'b1};
    riff_d      = riff_q;
    ph_d        = ph_q;
    tag_d       = tag_q;
    rem_d       = rem_q;
    fs_d        = fs_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    dbytes_d    = dbytes_q;
    hold_d      = hold_q;
    peak_d      = peak_q;
    err_d       = err_q;
    emit_sample = 1'b0;
    k           = fs_q[2:0];
    off         = 4'd0 - rem_q[3:0];
    rem_dec     = rem_q - {{(wpsv_pkg::LenW-1){1'b0}}, 1'b1};
    raw         = {b, hold_q[7:0]};
    mag         = raw[15] ? 17'd0 - {1'b1, raw} : {1'b0, raw};
    body_end    = {1'b0, pos_d} + {2'b0, rem_q};

    case (ph_q)
      wpsv_pkg::PH_HEADER: begin
        if (pos_q[3:0] >= 4'd4 && pos_q[3:0] < 4'd8) begin
          riff_d = riff_q | ({24'd0, b} << {pos_q[1:0], 3'b000});
          if (pos_q[3:0] >= 4'd11) begin
            ph_d = wpsv_pkg::PH_CHDR;
            fs_d = 4'd0;
          end
        end else if (b != wpsv_pkg::hdr_expect(pos_q[3:0])) begin
          if (err_q == wpsv_pkg::ST_OK) err_d = wpsv_pkg::ST_INVALID;
          ph_d = wpsv_pkg::PH_HALT;
        end else if (pos_q[3:0] >= 4'd11) begin
          ph_d = wpsv_pkg::PH_CHDR;
          fs_d = 4'd0;
        end
      end
      wpsv_pkg::PH_CHDR: begin
        if (k == 3'd0) begin
          tag_d = '0;
          rem_d = '0;
        end
        if (!k[2]) tag_d = tag_d | ({24'd0, b} << {k[1:0], 3'b000});
        else       rem_d = rem_d | ({24'd0, b} << {k[1:0], 3'b000});
        fs_d = {1'b0, k} + 4'd1;
        if (k == 3'd7) begin
          body_end = {1'b0, pos_d} + {2'b0, rem_d};
          if (body_end > {2'b0, riff_q} + 34'd8) begin
            if (err_q == wpsv_pkg::ST_OK) err_d = wpsv_pkg::ST_TRUNC;
            ph_d = wpsv_pkg::PH_HALT;
          end else if (tag_d == wpsv_pkg::TagFmt && rem_d != 32'd16) begin
            if (err_q == wpsv_pkg::ST_OK) err_d = wpsv_pkg::ST_BAD_FMT;
            ph_d = wpsv_pkg::PH_HALT;
          end else if (tag_d == wpsv_pkg::TagData && data_seen_q) begin
            if (err_q == wpsv_pkg::ST_OK) err_d = wpsv_pkg::ST_DUP_DATA;
            ph_d = wpsv_pkg::PH_HALT;
          end else begin
            if (tag_d == wpsv_pkg::TagFmt) begin
              fmt_seen_d = 1'b1;
              ph_d       = wpsv_pkg::PH_FMT;
            end else if (tag_d == wpsv_pkg::TagData) begin
              data_seen_d = 1'b1;
              dbytes_d    = rem_d;
              hold_d      = '0;
              ph_d        = wpsv_pkg::PH_DATA;
            end else begin
              ph_d = wpsv_pkg::PH_OTHER;
            end
            fs_d = {3'd0, rem_d[0]};
            if (rem_d == '0) begin
              ph_d = wpsv_pkg::PH_CHDR;
              fs_d = 4'd0;
            end
          end
        end
      end
      wpsv_pkg::PH_FMT: begin
        if (wpsv_pkg::fmt_care(off) && b != wpsv_pkg::fmt_expect(off)) begin
          if (err_q == wpsv_pkg::ST_OK) err_d = wpsv_pkg::ST_BAD_FMT;
          ph_d = wpsv_pkg::PH_HALT;
        end else begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            ph_d = fs_q[0] ? wpsv_pkg::PH_PAD : wpsv_pkg::PH_CHDR;
            if (!fs_q[0]) fs_d = 4'd0;
          end
        end
      end
      wpsv_pkg::PH_DATA: begin
        if (hold_q[8]) begin
          emit_sample = 1'b1;
          if (mag[15:0] > peak_q) peak_d = mag[15:0];
          hold_d = '0;
        end else begin
          hold_d = {1'b1, b};
        end
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          ph_d = fs_q[0] ? wpsv_pkg::PH_PAD : wpsv_pkg::PH_CHDR;
          if (!fs_q[0]) fs_d = 4'd0;
        end
      end
      wpsv_pkg::PH_OTHER: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          ph_d = fs_q[0] ? wpsv_pkg::PH_PAD : wpsv_pkg::PH_CHDR;
          if (!fs_q[0]) fs_d = 4'd0;
        end
      end
      wpsv_pkg::PH_PAD: begin
        ph_d = wpsv_pkg::PH_CHDR;
        fs_d = 4'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    riff_total = {1'b0, riff_d} + 33'd8;
    count      = dbytes_d[wpsv_pkg::LenW-1:1];
    if (pos_d < wpsv_pkg::MinFileLen || riff_total != pos_d ||
        err_d == wpsv_pkg::ST_INVALID) begin
      status = wpsv_pkg::ST_INVALID;
    end else if (err_d != wpsv_pkg::ST_OK) begin
      status = err_d;
    end else if (ph_d != wpsv_pkg::PH_CHDR || fs_d != 4'd0 || !fmt_seen_d ||
                 !data_seen_d || dbytes_d[0]) begin
      status = wpsv_pkg::ST_BAD_STRUC;
    end else if (count < min_q || count > max_q) begin
      status = wpsv_pkg::ST_BAD_DUR;
    end else begin
      status = wpsv_pkg::ST_OK;
    end

    sample_e                = '0;
    sample_e.res.sample_q15 = raw;
    summ_e                  = '0;
    summ_e.kind             = 1'b1;
    summ_e.res.status       = status;
    summ_e.res.sample_count = count;
    summ_e.res.play_ms      = count[wpsv_pkg::CountW-1:4];
    summ_e.res.peak_level   = peak_d;
    summ_e.res.quiet_flag   = (peak_d <= sil_q);

    e0     = emit_sample ? sample_e : summ_e;
    n_push = accept ? ({1'b0, emit_sample} + {1'b0, s_axis_tlast}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      riff_q      <= '0;
      ph_q        <= wpsv_pkg::PH_HEADER;
      tag_q       <= '0;
      rem_q       <= '0;
      fs_q        <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      dbytes_q    <= '0;
      hold_q      <= '0;
      peak_q      <= '0;
      err_q       <= wpsv_pkg::ST_OK;
    end else if (accept) begin
      if (s_axis_tlast) begin
        pos_q       <= '0;
        riff_q      <= '0;
        ph_q        <= wpsv_pkg::PH_HEADER;
        tag_q       <= '0;
        rem_q       <= '0;
        fs_q        <= '0;
        fmt_seen_q  <= 1'b0;
        data_seen_q <= 1'b0;
        dbytes_q    <= '0;
        hold_q      <= '0;
        peak_q      <= '0;
        err_q       <= wpsv_pkg::ST_OK;
      end else begin
        pos_q       <= pos_d;
        riff_q      <= riff_d;
        ph_q        <= ph_d;
        tag_q       <= tag_d;
        rem_q       <= rem_d;
        fs_q        <= fs_d;
        fmt_seen_q  <= fmt_seen_d;
        data_seen_q <= data_seen_d;
        dbytes_q    <= dbytes_d;
        hold_q      <= hold_d;
        peak_q      <= peak_d;
        err_q       <= err_d;
      end
    end
  end

  // output queue
  assign s_axis_tready = (cnt_q <= 3'd2);
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {2'b00, q_mem[rd_q].res};
  assign m_axis_tuser  = q_mem[rd_q].kind;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) q_mem[wr_q] <= e0;
    if (n_push == 2'd2) q_mem[wr_q + 2'd1] <= summ_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop};
    end
  end

endmodule

// ===== tb/sv/tb_wave_pcm16_stream_validator_top.sv =====
module tb_wave_pcm16_stream_validator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wpsv_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  wave_pcm16_stream_validator_top u_top (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // parser model state
  logic [CountW-1:0]  min_cnt, max_cnt;
  logic [PeakW-1:0]   quiet_peak;
  logic [PosW-1:0]    pos_q;
  logic [PosW-1:0]    riff_len_q;
  logic [2:0]         phase_q;
  logic [31:0]        tag_q;
  logic [PosW-1:0]    remain_q;
  logic [31:0]        shift_q;
  logic               fmt_seen_q, data_seen_q;
  logic [31:0]        data_len_q;
  logic [8:0]         hold_q;
  logic [16:0]        peak_q;
  logic [StatusW-1:0] err_q;

  entry_t word_q[$];
  int     errors;
  int     idle_cycles;
  int     send_idle_pct, recv_stall_pct;

  function automatic entry_t mk_word(logic kind, logic [15:0] smp, logic [2:0] st,
                                     logic [30:0] cnt, logic [26:0] dur,
                                     logic [15:0] pk, logic qf);
    entry_t w;
    w.kind = kind;
    w.res.sample_q15 = smp;
    w.res.status = st;
    w.res.sample_count = cnt;
    w.res.play_ms = dur;
    w.res.peak_level = pk;
    w.res.quiet_flag = qf;
    return w;
  endfunction

  function automatic void clear_parser();
    pos_q = '0; riff_len_q = '0; phase_q = PH_HEADER; tag_q = '0; remain_q = '0;
    shift_q = '0; fmt_seen_q = 1'b0; data_seen_q = 1'b0; data_len_q = '0;
    hold_q = '0; peak_q = '0; err_q = ST_OK;
  endfunction

  function automatic void latch_err(logic [2:0] code);
    if (err_q == ST_OK) err_q = code;
    phase_q = PH_HALT;
  endfunction

  function automatic void close_body();
    if (shift_q[0]) phase_q = PH_PAD;
    else begin
      phase_q = PH_CHDR;
      shift_q = '0;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    logic [PosW-1:0] p;
    logic [PosW:0]   lim;
    logic [2:0]      k;
    logic [3:0]      off;
    logic [15:0]     raw;
    logic [16:0]     mag;
    logic [30:0]     cnt;
    logic [2:0]      st;
    logic [PosW:0]   tot;
    p = pos_q;
    if (pos_q != {PosW{1'b1}}) pos_q = pos_q + PosW'(1);
    case (phase_q)
      PH_HEADER: begin
        if (p >= 4 && p < 8) riff_len_q = riff_len_q | ({25'd0, b} << (8 * (p - 4)));
        else if (p < 12 && b != hdr_expect(p[3:0])) begin
          latch_err(ST_INVALID);
        end
        if (phase_q == PH_HEADER && p >= 11) begin
          phase_q = PH_CHDR;
          shift_q = '0;
        end
      end
      PH_CHDR: begin
        k = shift_q[2:0];
        if (k == 0) begin
          tag_q = '0;
          remain_q = '0;
        end
        if (k < 4) tag_q = tag_q | ({24'd0, b} << (8 * k));
        else remain_q = remain_q | ({25'd0, b} << (8 * (k - 4)));
        shift_q = 32'(k) + 32'd1;
        if (k == 7) begin
          lim = {1'b0, pos_q} + {1'b0, remain_q};
          if (lim > {1'b0, riff_len_q} + 8) latch_err(ST_TRUNC);
          else if (tag_q == TagFmt && remain_q != 16) latch_err(ST_BAD_FMT);
          else if (tag_q == TagData && data_seen_q) latch_err(ST_DUP_DATA);
          else begin
            if (tag_q == TagFmt) begin
              fmt_seen_q = 1'b1;
              phase_q = PH_FMT;
            end else if (tag_q == TagData) begin
              data_seen_q = 1'b1;
              data_len_q = remain_q[31:0];
              hold_q = '0;
              phase_q = PH_DATA;
            end else phase_q = PH_OTHER;
            shift_q = {31'd0, remain_q[0]};
            if (remain_q == 0) close_body();
          end
        end
      end
      PH_FMT: begin
        off = 4'(16 - remain_q);
        if (fmt_care(off) && b != fmt_expect(off)) latch_err(ST_BAD_FMT);
        else begin
          remain_q = remain_q - PosW'(1);
          if (remain_q == 0) close_body();
        end
      end
      PH_DATA: begin
        if (hold_q[8]) begin
          raw = {b, hold_q[7:0]};
          mag = raw[15] ? 17'(-$signed({raw[15], raw})) : {1'b0, raw};
          if (mag > peak_q) peak_q = mag;
          hold_q = '0;
          word_q.insert(word_q.size(), mk_word(1'b0, raw, ST_OK, '0, '0, '0, 1'b0));
        end else hold_q = {1'b1, b};
        remain_q = remain_q - PosW'(1);
        if (remain_q == 0) close_body();
      end
      PH_OTHER: begin
        remain_q = remain_q - PosW'(1);
        if (remain_q == 0) close_body();
      end
      PH_PAD: begin
        phase_q = PH_CHDR;
        shift_q = '0;
      end
      default: ;
    endcase
    if (last) begin
      tot = {1'b0, pos_q};
      cnt = data_len_q[31:1];
      if (tot < 44 || {1'b0, riff_len_q} + 8 != tot || err_q == ST_INVALID) st = ST_INVALID;
      else if (err_q != ST_OK) st = err_q;
      else if (phase_q != PH_CHDR || shift_q != 0 || !fmt_seen_q || !data_seen_q ||
               data_len_q[0]) st = ST_BAD_STRUC;
      else if (cnt < min_cnt || cnt > max_cnt) st = ST_BAD_DUR;
      else st = ST_OK;
      word_q.insert(word_q.size(), mk_word(1'b1, '0, st, cnt, cnt[30:4], peak_q[15:0],
                                           peak_q <= {1'b0, quiet_peak}));
      clear_parser();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b, last);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [30:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_MIN_SAMPLES:  min_cnt = val;
      CFG_MAX_SAMPLES:  max_cnt = val;
      CFG_SILENCE_PEAK: quiet_peak = val[15:0];
      default: ;
    endcase
  endtask

  // file image built up byte by byte
  logic [7:0] img[$];

  function automatic void put8(logic [7:0] v);
    img.insert(img.size(), v);
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) put8(v[8*i +: 8]);
  endfunction

  function automatic void put_fmt(bit corrupt);
    logic [7:0] f[16];
    put32(TagFmt);
    put32(32'd16);
    for (int i = 0; i < 16; i++) f[i] = fmt_care(4'(i)) ? fmt_expect(4'(i)) : 8'($urandom);
    if (corrupt) f[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
    for (int i = 0; i < 16; i++) put8(f[i]);
  endfunction

  function automatic void put_chunk(logic [31:0] tag, int n, bit loud);
    put32(tag);
    put32(n);
    for (int i = 0; i < n; i++) begin
      if (loud) put8(8'($urandom));
      else if (i % 2) put8($urandom_range(1) ? 8'hFF : 8'h00);
      else put8(8'($urandom_range(90)));
    end
    if (n % 2) put8(8'($urandom));
  endfunction

  // well-formed file, optionally broken afterward
  function automatic void build_wave(int nsamp, bit loud);
    img.delete();
    put32(32'h4646_4952);
    put32(0);
    put32(32'h4556_4157);
    if ($urandom_range(3) == 0) put_chunk(32'h5453_494C, $urandom_range(5), 1'b1);
    put_fmt(1'b0);
    if ($urandom_range(4) == 0) put_chunk(32'h6B6E_756A, $urandom_range(7), 1'b1);
    put_chunk(TagData, 2 * nsamp, loud);
    if ($urandom_range(4) == 0) put_fmt(1'b0);
  endfunction

  function automatic void fix_riff();
    logic [31:0] l;
    l = img.size() - 8;
    for (int i = 0; i < 4; i++) img[4 + i] = l[8*i +: 8];
  endfunction

  task automatic send_file();
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
  endtask

  task automatic break_file();
    int m;
    m = $urandom_range(9);
    case (m)
      0: img[$urandom_range(img.size() - 1)] ^= 8'(1 << $urandom_range(7));
      1: img = img[0:$urandom_range(img.size() - 1)];
      2: img[4] ^= 8'(1 << $urandom_range(7));
      3: img[$urandom_range(11)] = 8'($urandom);
      4: begin
        put_chunk(TagData, 2, 1'b1);
        fix_riff();
      end
      5: begin
        put8(8'($urandom));
        fix_riff();
      end
      6: begin
        put32(TagData);
        fix_riff();
      end
      default: ;
    endcase
  endtask

  task automatic test_directed();
    // shortest file, a single byte
    img.delete();
    send_byte(8'h52, 1'b1);
    wait_drain();
    // extreme samples, header-only length 44, zero-size data
    write_reg(CFG_MIN_SAMPLES, 31'd0);
    build_wave(0, 1'b0);
    fix_riff();
    send_file();
    img.delete();
    put32(32'h4646_4952); put32(0); put32(32'h4556_4157); put_fmt(1'b0);
    put32(TagData); put32(32'd6);
    put8(8'h00); put8(8'h80);
    put8(8'hFF); put8(8'h7F);
    put8(8'hFF); put8(8'hFF);
    fix_riff();
    send_file();
    // bad fmt size, odd data, missing fmt, truncation, corrupt trailing fmt
    img.delete();
    put32(32'h4646_4952); put32(0); put32(32'h4556_4157);
    put32(TagFmt); put32(32'd18);
    repeat (18) put8(8'h00);
    fix_riff();
    send_file();
    img.delete();
    put32(32'h4646_4952); put32(0); put32(32'h4556_4157); put_fmt(1'b0);
    put_chunk(TagData, 3, 1'b1);
    fix_riff();
    send_file();
    img.delete();
    put32(32'h4646_4952); put32(0); put32(32'h4556_4157);
    put_chunk(TagData, 40, 1'b1);
    fix_riff();
    send_file();
    build_wave(4, 1'b1);
    fix_riff();
    img[img.size() - 12] = 8'hFF;
    send_file();
    build_wave(3, 1'b1);
    put_fmt(1'b1);
    fix_riff();
    send_file();
    wait_drain();
  endtask

  task automatic run_random(int nfiles, int max_n);
    for (int f = 0; f < nfiles; f++) begin
      build_wave($urandom_range(max_n), 1'($urandom_range(1)));
      fix_riff();
      if ($urandom_range(3) == 0) break_file();
      send_file();
    end
    wait_drain();
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(2, 20);
    send_idle_pct = 86; recv_stall_pct = 0;  run_random(2, 20);
    send_idle_pct = 0;  recv_stall_pct = 86; run_random(2, 20);
    send_idle_pct = 8;  recv_stall_pct = 8;  run_random(2, 20);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  task automatic test_limits();
    write_reg(CFG_MIN_SAMPLES, 31'd10);
    write_reg(CFG_MAX_SAMPLES, 31'd20);
    write_reg(CFG_SILENCE_PEAK, 31'd0);
    run_random(2, 25);
    write_reg(CFG_MIN_SAMPLES, 31'h7FFF_FFFF);
    write_reg(CFG_MAX_SAMPLES, 31'h7FFF_FFFF);
    write_reg(CFG_SILENCE_PEAK, 31'd32768);
    run_random(1, 10);
    write_reg(CFG_MIN_SAMPLES, 31'd0);
    write_reg(CFG_MAX_SAMPLES, 31'd0);
    write_reg(CFG_SILENCE_PEAK, 31'd100);
    run_random(1, 3);
    write_reg(CFG_MIN_SAMPLES, 31'd2);
    write_reg(CFG_MAX_SAMPLES, 31'h7FFF_FFFF);
    write_reg(CFG_SILENCE_PEAK, 31'hFFFF);
    run_random(1, 30);
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    entry_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.res  = m_axis_tdata[$bits(result_t)-1:0];
        if (word_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word kind=%0d data=%h", got.kind, got.res);
        end else begin
          want = word_q.pop_front();
          if (got != want || m_axis_tdata[OutDataW-1:$bits(result_t)] != '0) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch kind %0d/%0d smp %h/%h st %0d/%0d cnt %0d/%0d",
                       want.kind, got.kind, want.res.sample_q15, got.res.sample_q15,
                       want.res.status, got.res.status, want.res.sample_count,
                       got.res.sample_count);
              $display("  dur %0d/%0d pk %0d/%0d quiet %0d/%0d",
                       want.res.play_ms, got.res.play_ms,
                       want.res.peak_level, got.res.peak_level,
                       want.res.quiet_flag, got.res.quiet_flag);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("wave_pcm16_stream_validator_top regression: fail");
      $finish;
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    min_cnt = MinSamplesRst; max_cnt = MaxSamplesRst; quiet_peak = SilencePeakRst;
    clear_parser();
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0; cfg_we_i = 1'b0; cfg_addr_i = '0; cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_phases();
    test_limits();
    wait_drain();
    if (errors == 0) $display("wave_pcm16_stream_validator_top regression: pass");
    else $display("wave_pcm16_stream_validator_top regression: fail");
    $finish;
  end

endmodule

// ===== wave_pcm16_stream_validator_top.f =====
sv/wpsv_pkg.sv
sv/wave_pcm16_stream_validator_top.sv
tb/sv/tb_wave_pcm16_stream_validator_top.sv
